/* design/fan_duty_from_temperature_core_assert.svh */
// Assertion macros for the fan duty core checker.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef FAN_DUTY_FROM_TEMPERATURE_CORE_ASSERT_SVH
`define FAN_DUTY_FROM_TEMPERATURE_CORE_ASSERT_SVH

// same-cycle implication
`define FDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fdt assertion failed");

// next-cycle implication
`define FDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fdt assertion failed");

`endif

/* design/fdt_pkg.sv */
// Shared types and constants for the fan duty core.
// No dependencies.
package fdt_pkg;

  localparam int TempW  = 12;
  localparam int HystW  = 9;
  localparam int DutyW  = 8;
  localparam int ProdW  = TempW + DutyW;
  localparam int CntW   = $clog2(DutyW);
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 12;

  localparam logic [CfgIdxW-1:0] RegTempLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTempHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHyst     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinDuty  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxDuty  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

endpackage

/* design/fan_duty_from_temperature_core.sv */
// Fan duty core: temperature sample in, PWM duty and fan flag out.
// A request is taken only in idle. Without interpolation it goes straight to the
// finish state; when interpolating it first runs the bit-serial divider. The
// finish state loads the result register once the previous result has left it,
// and only then does the core return to idle and take a new request.
// Reset: settings and control registers default, fan flag set, no result pending.
module fan_duty_from_temperature_core import fdt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [TempW-1:0]  temperature_i,
  input  logic                     sample_valid_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DutyW-1:0]         duty_o,
  output logic                     fan_running_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDatW-1:0]       cfg_data_i
);

  logic signed [TempW-1:0] temp_low_q, temp_high_q;
  logic [HystW-1:0]        hyst_q;
  logic [DutyW-1:0]        min_duty_q, max_duty_q;
  logic                    fan_on_q;

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TempW-1:0] rem_q, rem_d;
  logic [DutyW-1:0] dsh_q, dsh_d;
  logic [DutyW-1:0] quo_q, quo_d;
  logic [TempW-1:0] den_q;
  logic [DutyW-1:0] lo_q, direct_q;
  logic             interp_q;
  logic             out_valid_q;
  logic [DutyW-1:0] duty_q;

  logic             accept, load_out;
  logic [DutyW-1:0] result_duty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_q  <= 12'sd260;
      temp_high_q <= 12'sd303;
      hyst_q      <= 9'd50;
      min_duty_q  <= 8'd10;
      max_duty_q  <= 8'd255;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTempLow:  temp_low_q  <= cfg_data_i;
        RegTempHigh: temp_high_q <= cfg_data_i;
        RegHyst:     hyst_q      <= cfg_data_i[HystW-1:0];
        RegMinDuty:  min_duty_q  <= cfg_data_i[DutyW-1:0];
        RegMaxDuty:  max_duty_q  <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Request decode: thresholds in half tenths, interpolation operands.
  logic signed [TempW+2:0] t2, low_minus, low_plus;
  logic signed [TempW:0]   num_full, den_full;
  logic [TempW-1:0]        num, den;
  logic [DutyW-1:0]        span;
  logic [ProdW-1:0]        prod;
  logic                    lt_low, lt_high, need_div;
  logic [DutyW-1:0]        direct;

  always_comb begin
    t2        = {{2{temperature_i[TempW-1]}}, temperature_i, 1'b0};
    low_minus = {{2{temp_low_q[TempW-1]}}, temp_low_q, 1'b0}
                - $signed({{(TempW+3-HystW){1'b0}}, hyst_q});
    low_plus  = {{2{temp_low_q[TempW-1]}}, temp_low_q, 1'b0}
                + $signed({{(TempW+3-HystW){1'b0}}, hyst_q});
    num_full  = {temperature_i[TempW-1], temperature_i}
                - {temp_low_q[TempW-1], temp_low_q};
    den_full  = {temp_high_q[TempW-1], temp_high_q}
                - {temp_low_q[TempW-1], temp_low_q};
    num       = num_full[TempW-1:0];
    den       = den_full[TempW-1:0];
    span      = (max_duty_q > min_duty_q) ? (max_duty_q - min_duty_q) : '0;
    prod      = ProdW'(num) * ProdW'(span);
    lt_low    = temperature_i < temp_low_q;
    lt_high   = temperature_i < temp_high_q;
    need_div  = 1'b0;
    direct    = max_duty_q;
    if (!sample_valid_i) begin
      direct = max_duty_q;
    end else if (lt_low) begin
      direct = (fan_on_q && !(t2 < low_minus)) ? min_duty_q : '0;
    end else if (lt_high) begin
      if (fan_on_q) begin
        need_div = 1'b1;
      end else begin
        direct = (t2 > low_plus) ? min_duty_q : '0;
      end
    end
  end

  // One restoring-division step: shift in a dividend bit, try the subtract.
  logic [TempW:0] trial, diff;
  always_comb begin
    trial = {rem_q, dsh_q[DutyW-1]};
    diff  = trial - {1'b0, den_q};
  end

  assign result_duty = interp_q ? (lo_q + quo_q) : direct_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    dsh_d      = dsh_q;
    quo_d      = quo_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // Quotient fits in DutyW bits, so the upper product bits seed the remainder.
          rem_d   = prod[ProdW-1:DutyW];
          dsh_d   = prod[DutyW-1:0];
          quo_d   = '0;
          cnt_d   = '0;
          state_d = need_div ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        if (!diff[TempW]) begin
          rem_d = diff[TempW-1:0];
        end else begin
          rem_d = trial[TempW-1:0];
        end
        quo_d = {quo_q[DutyW-2:0], ~diff[TempW]};
        dsh_d = {dsh_q[DutyW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DutyW - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold until the result register is free.
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fan_on_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        fan_on_q    <= (result_duty != '0);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    if (accept) begin
      den_q    <= den;
      lo_q     <= min_duty_q;
      direct_q <= direct;
      interp_q <= need_div;
    end
    if (load_out) begin
      duty_q <= result_duty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign duty_o        = duty_q;
  assign fan_running_o = (duty_q != '0);

endmodule

/* design/fdt_checker.sv */
// Port-level checker for the fan duty core, bound to the top level.
// Depends on fdt_pkg and fan_duty_from_temperature_core_assert.svh.
`include "fan_duty_from_temperature_core_assert.svh"

module fdt_checker import fdt_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [DutyW-1:0]        duty_o,
  input logic                    fan_running_o
);

  // a stalled result holds its value
  `FDT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(duty_o))
  // fan flag tracks a nonzero duty
  `FDT_ASSERT_IMP(a_fan_flag, out_valid_o, fan_running_o == (duty_o != '0))
  // a request blocks the input until it has finished
  `FDT_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o)
  // no result appears in the cycle right after a request
  `FDT_ASSERT_NEXT(a_min_latency, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind fan_duty_from_temperature_core fdt_checker u_fdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .duty_o        (duty_o),
  .fan_running_o (fan_running_o)
);

/* tb/tb_fan_duty_from_temperature_core.sv */
// Testbench for fan_duty_from_temperature_core: directed table, then random phases.
// Checks each result against an in-bench fan curve predictor.
// Depends on fdt_pkg and the core RTL only.
module tb_fan_duty_from_temperature_core import fdt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemsPerPhase = 38;
  localparam int NumPhases     = 14;
  localparam logic [CfgIdxW-1:0] RegSpare = RegMaxDuty + 3'd1;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             fan;
  } fan_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [TempW-1:0]   val;
    logic               sv;
    logic               typed;
    logic [DutyW-1:0]   duty;
    logic               fan;
  } row_t;

  localparam int NumRows = 31;

  // Directed table: reset settings first, then the corner settings.
  row_t dir_tab [NumRows] = '{
    '{ROW_ITEM, RegTempLow, 12'd2047, 1'b1, 1'b1, 8'd255, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'h800,  1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'h800,  1'b0, 1'b1, 8'd255, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'd200,  1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd280,  1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd285,  1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd286,  1'b1, 1'b1, 8'd10,  1'b1},
    '{ROW_ITEM, RegTempLow, 12'd290,  1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd302,  1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd303,  1'b1, 1'b1, 8'd255, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'd260,  1'b1, 1'b1, 8'd10,  1'b1},
    '{ROW_ITEM, RegTempLow, 12'd235,  1'b1, 1'b1, 8'd10,  1'b1},
    '{ROW_ITEM, RegTempLow, 12'd234,  1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd1250, 1'b0, 1'b1, 8'd255, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'hE70,  1'b1, 1'b1, 8'd0,   1'b0},
    // max duty below min duty
    '{ROW_CFG,  RegMaxDuty, 12'd5,    1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd0,    1'b0, 1'b1, 8'd5,   1'b1},
    '{ROW_ITEM, RegTempLow, 12'd280,  1'b1, 1'b0, 8'd0,   1'b0},
    // both duties zero
    '{ROW_CFG,  RegMinDuty, 12'd0,    1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  RegMaxDuty, 12'd0,    1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd2047, 1'b1, 1'b1, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd100,  1'b0, 1'b1, 8'd0,   1'b0},
    // full speed temperature below the threshold
    '{ROW_CFG,  RegMaxDuty, 12'd200,  1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  RegTempHigh, 12'd200, 1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd260,  1'b1, 1'b1, 8'd200, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'd250,  1'b1, 1'b0, 8'd0,   1'b0},
    // write to an unused index, then widest hysteresis
    '{ROW_CFG,  RegSpare,   12'hFFF,  1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_CFG,  RegHyst,    12'h1FF,  1'b0, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd260,  1'b1, 1'b1, 8'd200, 1'b1},
    '{ROW_ITEM, RegTempLow, 12'd0,    1'b1, 1'b0, 8'd0,   1'b0},
    '{ROW_ITEM, RegTempLow, 12'd8,    1'b1, 1'b0, 8'd0,   1'b0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [TempW-1:0]   temperature_i;
  logic                      sample_valid_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [DutyW-1:0]          duty_o;
  logic                      fan_running_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgDatW-1:0]        cfg_data_i;

  // predictor state and settings
  int       thr_low;
  int       thr_high;
  int       hyst_band;
  int       duty_min;
  int       duty_max;
  bit       fan_on_q;

  fan_res_t duty_expect_q [$];
  int       n_errors;
  int       n_items;
  int       n_results;
  int       n_writes;
  bit       quiet;

  fan_duty_from_temperature_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .temperature_i  (temperature_i),
    .sample_valid_i (sample_valid_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .duty_o         (duty_o),
    .fan_running_o  (fan_running_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_settings();
    thr_low   = 260;
    thr_high  = 303;
    hyst_band = 50;
    duty_min  = 10;
    duty_max  = 255;
    fan_on_q  = 1'b1;
  endfunction

  function automatic void apply_setting(input logic [CfgIdxW-1:0] idx,
                                        input logic [CfgDatW-1:0] data);
    case (idx)
      RegTempLow:  thr_low   = $signed(data[TempW-1:0]);
      RegTempHigh: thr_high  = $signed(data[TempW-1:0]);
      RegHyst:     hyst_band = data[HystW-1:0];
      RegMinDuty:  duty_min  = data[DutyW-1:0];
      RegMaxDuty:  duty_max  = data[DutyW-1:0];
      default: ;
    endcase
  endfunction

  // Fan curve with hysteresis; advances fan_on_q.
  function automatic fan_res_t predict_duty(input logic signed [TempW-1:0] temp,
                                            input logic sv);
    int       t;
    int       span;
    int       d;
    fan_res_t r;
    t = temp;
    if (!sv) begin
      d = duty_max;
    end else if (t < thr_low) begin
      if (fan_on_q) d = (2 * t < 2 * thr_low - hyst_band) ? 0 : duty_min;
      else d = 0;
    end else if (t < thr_high) begin
      if (fan_on_q) begin
        span = (duty_max > duty_min) ? duty_max - duty_min : 0;
        d = duty_min + ((t - thr_low) * span) / (thr_high - thr_low);
      end else begin
        d = (2 * t > 2 * thr_low + hyst_band) ? duty_min : 0;
      end
    end else begin
      d = duty_max;
    end
    d = d & 255;
    fan_on_q = (d != 0);
    r.duty = d[DutyW-1:0];
    r.fan  = fan_on_q;
    return r;
  endfunction

  // Temperatures weighted toward the thresholds and the band.
  function automatic logic [TempW-1:0] pick_temp();
    int t;
    int band;
    band = (thr_high > thr_low) ? thr_high - thr_low : 0;
    case ($urandom_range(0, 9))
      0, 1, 2: t = thr_low - hyst_band - 8 + $urandom_range(0, 2 * hyst_band + 16);
      3, 4:    t = thr_low + $urandom_range(0, band);
      5: begin
        case ($urandom_range(0, 7))
          0: t = thr_low - (hyst_band + 1) / 2;
          1: t = thr_low - hyst_band / 2;
          2: t = thr_low + hyst_band / 2;
          3: t = thr_low + (hyst_band + 1) / 2;
          4: t = thr_low - 1;
          5: t = thr_low;
          6: t = thr_high - 1;
          default: t = thr_high;
        endcase
      end
      6, 7: t = $urandom_range(0, 1650) - 400;
      8:    t = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: t = -2048;
          1: t = 2047;
          2: t = -400;
          3: t = 1250;
          default: t = 0;
        endcase
      end
    endcase
    return t[TempW-1:0];
  endfunction

  // Hold off new requests until every pending result has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    while (duty_expect_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_setting(idx, data);
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Entered and left just after a falling edge; valid stays up for back-to-back requests.
  task automatic send_sample(input logic [TempW-1:0] temp, input logic sv,
                             input logic typed, input fan_res_t typed_res);
    fan_res_t r;
    while (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    temperature_i  = temp;
    sample_valid_i = sv;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_duty(temp, sv);
    duty_expect_q.push_back(typed ? typed_res : r);
    n_items++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i = quiet || ($urandom_range(0, 99) >= 20);
  end

  initial begin
    fan_res_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        n_results++;
        if (duty_expect_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result duty=%0d fan=%0b", $time, duty_o, fan_running_o);
        end else begin
          e = duty_expect_q.pop_front();
          if (duty_o !== e.duty) begin
            n_errors++;
            $display("%0t: duty expected %0d actual %0d", $time, e.duty, duty_o);
          end
          if (fan_running_o !== e.fan) begin
            n_errors++;
            $display("%0t: fan_running expected %0b actual %0b", $time, e.fan, fan_running_o);
          end
        end
      end
    end
  end

  initial begin
    fan_res_t tr;
    int lo;
    int hi;
    int hy;
    int mn;
    int mx;
    int waited;
    in_valid_i     = 1'b0;
    temperature_i  = '0;
    sample_valid_i = 1'b0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = RegTempLow;
    cfg_data_i     = '0;
    quiet          = 1'b0;
    n_errors       = 0;
    n_items        = 0;
    n_results      = 0;
    n_writes       = 0;
    reset_settings();
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, CfgDatW'(dir_tab[i].val));
      end else begin
        tr.duty = dir_tab[i].duty;
        tr.fan  = dir_tab[i].fan;
        send_sample(dir_tab[i].val, dir_tab[i].sv, dir_tab[i].typed, tr);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin lo = 260;   hi = 303;  hy = 50;  mn = 10;  mx = 255; end
        1: begin lo = -400;  hi = 1250; hy = 500; mn = 0;   mx = 255; end
        2: begin lo = -2048; hi = 2047; hy = 511; mn = 1;   mx = 254; end
        3: begin lo = 500;   hi = 500;  hy = 20;  mn = 30;  mx = 200; end
        4: begin lo = 800;   hi = 100;  hy = 100; mn = 50;  mx = 60;  end
        5: begin lo = 0;     hi = 40;   hy = 10;  mn = 200; mx = 100; end
        6: begin lo = 100;   hi = 1000; hy = 0;   mn = 0;   mx = 0;   end
        7: begin lo = 1250;  hi = -400; hy = 7;   mn = 255; mx = 255; end
        8: begin lo = 0;     hi = 1;    hy = 3;   mn = 0;   mx = 255; end
        default: begin
          lo = $urandom_range(0, 1600) - 400;
          hi = ($urandom_range(0, 3) != 0) ? lo + $urandom_range(1, 300)
                                           : $urandom_range(0, 1650) - 400;
          hy = $urandom_range(0, 500);
          mn = $urandom_range(0, 255);
          mx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(mn, 255);
          // stray upper bits on the narrow registers
          if ($urandom_range(0, 2) == 0) begin
            hy = hy | ($urandom_range(0, 7) << HystW);
            mn = mn | ($urandom_range(0, 15) << DutyW);
            mx = mx | ($urandom_range(0, 15) << DutyW);
          end
        end
      endcase
      quiet = (p == 4 || p == 5);
      write_reg(RegTempLow,  lo[CfgDatW-1:0]);
      write_reg(RegTempHigh, hi[CfgDatW-1:0]);
      write_reg(RegHyst,     hy[CfgDatW-1:0]);
      write_reg(RegMinDuty,  mn[CfgDatW-1:0]);
      write_reg(RegMaxDuty,  mx[CfgDatW-1:0]);
      write_reg(RegSpare + 3'($urandom_range(0, 2)), 12'($urandom));
      for (int k = 0; k < ItemsPerPhase; k++) begin
        if (p == 2 && k == ItemsPerPhase / 2) drain();
        send_sample(pick_temp(), $urandom_range(0, 99) >= 8, 1'b0, tr);
      end
    end
    quiet = 1'b0;
    in_valid_i = 1'b0;

    waited = 0;
    while (duty_expect_q.size() != 0 && waited < 5000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (20) @(negedge clk_i);
    if (duty_expect_q.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived", $time, duty_expect_q.size());
    end

    $display("Sent %0d samples over %0d register writes, checked %0d results.",
             n_items, n_writes, n_results);
    $display("Settings included empty and inverted bands, zero and crossed duties.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
